FILE: hdl/dpq_pkg.sv
// Package for the deduplicating packet queue.
// Holds sizes, command and status codes; used by dedup_packet_queue_unit and dpq_checker.
`default_nettype none
package dpq_pkg;
    localparam int Capacity  = 1024;
    localparam int IdxW      = $clog2(Capacity);
    localparam int CntW      = IdxW + 1;
    localparam int IdW       = 32;
    localparam int HdlW      = 32;
    localparam int MaxW      = 11;
    localparam logic [MaxW-1:0] MaxReset = MaxW'(800);
    localparam int AddrW     = 2;

    typedef enum logic [2:0] {
        CMD_PUSH_BACK  = 3'd0,
        CMD_PUSH_FRONT = 3'd1,
        CMD_POP        = 3'd2,
        CMD_ERASE      = 3'd3,
        CMD_PEEK       = 3'd4
    } t_cmd;

    localparam logic [2:0] ST_OK       = 3'd0;
    localparam logic [2:0] ST_FULL     = 3'd1;
    localparam logic [2:0] ST_DUP      = 3'd2;
    localparam logic [2:0] ST_EMPTY    = 3'd3;
    localparam logic [2:0] ST_NOTFOUND = 3'd4;

    localparam logic [AddrW-1:0] RegMaxEntries = AddrW'(0);
endpackage
`default_nettype wire

FILE: hdl/dpq_ram.sv
// Generic single-port-write, single-port-read RAM with registered read.
// No dependencies.
`default_nettype none
module dpq_ram #(
    parameter int Width = 32,
    parameter int Depth = 1024
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
`default_nettype wire

FILE: hdl/dedup_packet_queue_unit.sv
// Top level of the deduplicating packet queue: sequencer plus two RAMs.
// Depends on dpq_pkg and dpq_ram.
`default_nettype none
// One request is worked at a time, and ready is low while it runs. An
// unknown command, a refused-full push, or a pop or peek of an empty queue
// goes straight to its result. Pop and peek read the head first. A push
// scans every held entry for a duplicate id through the single read port
// of the id memory, one entry a cycle. An erase scans up to the match,
// then shifts each later entry down one slot, one read and one write a
// cycle. Ready rises again in the cycle the result appears. The result
// is held in an output register until taken, so the next request can be
// accepted and worked meanwhile; it then waits in its last step until the
// register is free. No clearing pass.
module dedup_packet_queue_unit (
    input  wire logic                      i_clk,
    input  wire logic                      i_rst_n,
    input  wire logic                      i_valid,
    output logic                           o_ready,
    input  wire logic [2:0]                i_command,
    input  wire logic [dpq_pkg::IdW-1:0]   i_in_packet_id,
    input  wire logic [dpq_pkg::HdlW-1:0]  i_in_handle,
    output logic                           o_valid,
    input  wire logic                      i_ready,
    output logic      [2:0]                o_status,
    output logic      [dpq_pkg::IdW-1:0]   o_out_packet_id,
    output logic      [dpq_pkg::HdlW-1:0]  o_out_handle,
    output logic      [dpq_pkg::CntW-1:0]  o_occupancy,
    input  wire logic                      psel,
    input  wire logic                      penable,
    input  wire logic                      pwrite,
    input  wire logic [dpq_pkg::AddrW-1:0] paddr,
    input  wire logic [31:0]               pwdata,
    output logic      [31:0]               prdata,
    output logic                           pready
);
    localparam int IdxW = dpq_pkg::IdxW;
    localparam int CntW = dpq_pkg::CntW;

    typedef enum logic [2:0] {
        S_IDLE, S_DECIDE, S_SCAN, S_SHIFT, S_FRONT, S_DONE
    } t_state;

    t_state              r_state;
    logic [2:0]          r_cmd;
    logic [dpq_pkg::IdW-1:0]  r_id;
    logic [dpq_pkg::HdlW-1:0] r_hdl;
    logic [IdxW-1:0]     r_head;
    logic [CntW-1:0]     r_count;
    logic [CntW-1:0]     r_pos;      // position of the entry being read; the hole while shifting
    logic                r_rd_pend;  // a read was issued last cycle and its data is valid now
    logic [dpq_pkg::MaxW-1:0] r_max;
    logic [2:0]          r_status;
    logic [dpq_pkg::IdW-1:0]  r_oid;
    logic [dpq_pkg::HdlW-1:0] r_ohdl;
    logic                r_ovalid;
    logic [2:0]          r_out_status;
    logic [dpq_pkg::IdW-1:0]  r_out_id;
    logic [dpq_pkg::HdlW-1:0] r_out_hdl;
    logic [CntW-1:0]     r_out_occ;

    logic                we;
    logic [IdxW-1:0]     waddr, raddr;
    logic [dpq_pkg::IdW-1:0]  wid, rid;
    logic [dpq_pkg::HdlW-1:0] whdl, rhdl;
    logic [CntW-1:0]     limit;
    logic [IdxW-1:0]     pos_slot;
    logic                out_load;

    assign limit = (r_max > dpq_pkg::MaxW'(dpq_pkg::Capacity))
                 ? CntW'(dpq_pkg::Capacity) : CntW'(r_max);
    assign pos_slot = r_head + r_pos[IdxW-1:0];
    assign out_load = (r_state == S_DONE) && (!r_ovalid || i_ready);

    dpq_ram #(.Width(dpq_pkg::IdW), .Depth(dpq_pkg::Capacity)) u_id_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wid),
        .i_raddr(raddr), .o_rdata(rid)
    );
    dpq_ram #(.Width(dpq_pkg::HdlW), .Depth(dpq_pkg::Capacity)) u_hdl_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(whdl),
        .i_raddr(raddr), .o_rdata(rhdl)
    );

    // Read address: the current scan position, or when shifting r_pos+1, then
    // r_pos+2 once a read is pending (data for r_pos+1 is moved into slot r_pos).
    always_comb begin
        raddr = pos_slot;
        we    = 1'b0;
        waddr = pos_slot;
        wid   = rid;
        whdl  = rhdl;
        if (r_state == S_SHIFT) begin
            raddr = r_rd_pend ? pos_slot + IdxW'(2) : pos_slot + IdxW'(1);
            we    = r_rd_pend;
        end
        if (r_state == S_DECIDE && (r_cmd == dpq_pkg::CMD_PUSH_BACK ||
                                    r_cmd == dpq_pkg::CMD_PUSH_FRONT) &&
            r_status == dpq_pkg::ST_OK) begin
            we    = 1'b1;
            waddr = (r_cmd == dpq_pkg::CMD_PUSH_BACK)
                  ? r_head + r_count[IdxW-1:0] : r_head - IdxW'(1);
            wid   = r_id;
            whdl  = r_hdl;
        end
    end

    assign o_ready = (r_state == S_IDLE);
    assign o_valid = r_ovalid;
    assign o_status = r_out_status;
    assign o_out_packet_id = r_out_id;
    assign o_out_handle = r_out_hdl;
    assign o_occupancy = r_out_occ;
    assign pready = 1'b1;
    assign prdata = (paddr == dpq_pkg::RegMaxEntries) ? 32'(r_max) : 32'd0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state      <= S_IDLE;
            r_head       <= '0;
            r_count      <= '0;
            r_max        <= dpq_pkg::MaxReset;
            r_ovalid     <= 1'b0;
            r_rd_pend    <= 1'b0;
            r_pos        <= '0;
            r_status     <= dpq_pkg::ST_OK;
            r_out_status <= dpq_pkg::ST_OK;
            r_out_id     <= '0;
            r_out_hdl    <= '0;
            r_out_occ    <= '0;
        end else begin
            if (psel && penable && pwrite && paddr == dpq_pkg::RegMaxEntries) begin
                r_max <= pwdata[dpq_pkg::MaxW-1:0];
            end
            // The output register is refilled in the cycle it is taken.
            if (out_load) begin
                r_ovalid     <= 1'b1;
                r_out_status <= r_status;
                r_out_id     <= r_oid;
                r_out_hdl    <= r_ohdl;
                r_out_occ    <= r_count;
            end else if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_cmd     <= i_command;
                        r_id      <= i_in_packet_id;
                        r_hdl     <= i_in_handle;
                        r_oid     <= '0;
                        r_ohdl    <= '0;
                        r_status  <= dpq_pkg::ST_OK;
                        r_pos     <= '0;
                        r_rd_pend <= 1'b0;
                        unique case (i_command)
                            dpq_pkg::CMD_PUSH_BACK, dpq_pkg::CMD_PUSH_FRONT: begin
                                if (r_count >= limit) begin
                                    r_status <= dpq_pkg::ST_FULL;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_SCAN;
                                end
                            end
                            dpq_pkg::CMD_ERASE: r_state <= S_SCAN;
                            dpq_pkg::CMD_POP, dpq_pkg::CMD_PEEK: begin
                                if (r_count == '0) begin
                                    r_status <= dpq_pkg::ST_EMPTY;
                                    r_state  <= S_DONE;
                                end else begin
                                    r_state <= S_FRONT;
                                end
                            end
                            default: r_state <= S_DONE;
                        endcase
                    end
                end
                S_SCAN: begin
                    // Compare the entry read last cycle; issue the next read.
                    if (r_rd_pend && rid == r_id) begin
                        r_rd_pend <= 1'b0;
                        if (r_cmd == dpq_pkg::CMD_ERASE) begin
                            r_pos   <= r_pos - CntW'(1);
                            r_state <= S_SHIFT;
                        end else begin
                            r_status <= dpq_pkg::ST_DUP;
                            r_state  <= S_DONE;
                        end
                    end else if (r_pos >= r_count) begin
                        if (r_cmd == dpq_pkg::CMD_ERASE) begin
                            r_status <= dpq_pkg::ST_NOTFOUND;
                            r_state  <= S_DONE;
                        end else begin
                            r_state <= S_DECIDE;
                        end
                    end else begin
                        r_rd_pend <= 1'b1;
                        r_pos     <= r_pos + CntW'(1);
                    end
                end
                S_SHIFT: begin
                    // r_pos is the hole; once a read is pending, the read issued now fetches
                    // r_pos+2 and the data arriving now is r_pos+1, written to r_pos.
                    if (r_rd_pend) begin
                        r_pos <= r_pos + CntW'(1);
                    end
                    if ((r_rd_pend ? r_pos + CntW'(2) : r_pos + CntW'(1)) >= r_count) begin
                        if (!r_rd_pend || r_pos + CntW'(2) >= r_count) begin
                            r_count <= r_count - CntW'(1);
                            r_state <= S_DONE;
                        end
                    end
                    r_rd_pend <= 1'b1;
                end
                S_DECIDE: begin
                    if (r_cmd == dpq_pkg::CMD_PUSH_FRONT) begin
                        r_head <= r_head - IdxW'(1);
                    end
                    r_count <= r_count + CntW'(1);
                    r_state <= S_DONE;
                end
                S_FRONT: begin
                    // When a read is pending, the read of the head was issued in the previous cycle.
                    if (r_rd_pend) begin
                        r_oid  <= rid;
                        r_ohdl <= rhdl;
                        if (r_cmd == dpq_pkg::CMD_POP) begin
                            r_head  <= r_head + IdxW'(1);
                            r_count <= r_count - CntW'(1);
                        end
                        r_state <= S_DONE;
                    end
                    r_rd_pend <= 1'b1;
                end
                S_DONE: begin
                    if (out_load) begin
                        r_state <= S_IDLE;
                    end
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end
endmodule
`default_nettype wire

FILE: hdl/dpq_checker.sv
// Port-level checker for dedup_packet_queue_unit, bound to the top level.
// Depends on dpq_pkg.
`default_nettype none
module dpq_checker (
    input wire logic                     i_clk,
    input wire logic                     i_rst_n,
    input wire logic                     i_valid,
    input wire logic                     o_ready,
    input wire logic                     o_valid,
    input wire logic                     i_ready,
    input wire logic [2:0]               o_status,
    input wire logic [dpq_pkg::CntW-1:0] o_occupancy,
    input wire logic                     pready
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && !i_ready |=> o_valid && $stable(o_status))
        else $error("result dropped while stalled");
    a_occ_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_occupancy <= dpq_pkg::CntW'(dpq_pkg::Capacity))
        else $error("occupancy above capacity");
    a_accept_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_valid && o_ready |=> !o_ready)
        else $error("ready stayed high after a request");
    a_pready: assert property (@(posedge i_clk) pready)
        else $error("pready low");
endmodule

bind dedup_packet_queue_unit dpq_checker u_dpq_checker (
    .i_clk(i_clk), .i_rst_n(i_rst_n), .i_valid(i_valid), .o_ready(o_ready),
    .o_valid(o_valid), .i_ready(i_ready), .o_status(o_status),
    .o_occupancy(o_occupancy), .pready(pready)
);
`default_nettype wire
